>>> design/smfl_pkg.sv
// ----------------------------------------------------------------------------
// smfl_pkg
// Shared widths, operation and status codes, and the command/status bundles
// passed between the slot map controller and its datapath.
// ----------------------------------------------------------------------------
package smfl_pkg;

   // Fixed field widths on the channels
   localparam int KIND_W     = 2;
   localparam int STAT_W     = 2;
   localparam int IDX_PORT_W = 6;
   localparam int CNT_PORT_W = 7;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NULL   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic ld_req;   // capture the request on a transfer
      logic rd_req;   // read all memories for the captured request
      logic clr_rd;   // clear walk: read the live bit of the current slot
      logic clr_wr;   // clear walk: free the current slot if live
      logic exec;     // commit the request and load the result register
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_clear; // captured request is a clear
      logic hw_zero;  // no slot has ever been created
      logic clr_last; // clear walk is at the last created slot
   } dp_sts_type;

endpackage

>>> design/smfl_if.sv
// ----------------------------------------------------------------------------
// smfl_req_if / smfl_rsp_if
// Valid/ready channels for requests into and results out of the slot map.
// ----------------------------------------------------------------------------
interface smfl_req_if
   import smfl_pkg::*;
#(
   parameter int HANDLE_BITS = 32
) ();
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [IDX_PORT_W-1:0]  slot_index;
   logic [HANDLE_BITS-1:0] handle;

   modport source (output valid, kind, slot_index, handle, input ready);
   modport sink   (input valid, kind, slot_index, handle, output ready);
endinterface

interface smfl_rsp_if
   import smfl_pkg::*;
#(
   parameter int HANDLE_BITS = 32
) ();
   logic                   valid;
   logic                   ready;
   logic [STAT_W-1:0]      status;
   logic [IDX_PORT_W-1:0]  result_index;
   logic [HANDLE_BITS-1:0] result_handle;
   logic [CNT_PORT_W-1:0]  free_slots;
   logic [CNT_PORT_W-1:0]  slots_used;
   logic                   all_free;

   modport source (output valid, status, result_index, result_handle, free_slots,
                   slots_used, all_free, input ready);
   modport sink   (input valid, status, result_index, result_handle, free_slots,
                   slots_used, all_free, output ready);
endinterface

>>> design/smfl_dp.sv
// ----------------------------------------------------------------------------
// smfl_dp
// Slot map datapath: request register, handle/live/free-stack memories,
// stack pointer, high-water count, clear walk counter and result register.
// ----------------------------------------------------------------------------
module smfl_dp
   import smfl_pkg::*;
#(
   parameter int SLOTS       = 64,
   parameter int HANDLE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_sts_type             sts,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [IDX_PORT_W-1:0]  req_slot_index,
   input  logic [HANDLE_BITS-1:0] req_handle,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [IDX_PORT_W-1:0]  rsp_result_index,
   output logic [HANDLE_BITS-1:0] rsp_result_handle,
   output logic [CNT_PORT_W-1:0]  rsp_free_slots,
   output logic [CNT_PORT_W-1:0]  rsp_slots_used,
   output logic                   rsp_all_free
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (IDX_PORT_W > CNT_W) ? IDX_PORT_W : CNT_W;

   // Captured request
   logic [KIND_W-1:0]      kind_ff;
   logic [IDX_PORT_W-1:0]  idx_ff;
   logic [HANDLE_BITS-1:0] handle_ff;

   // Counters
   logic [CNT_W-1:0] free_top_ff, free_top_in;
   logic [CNT_W-1:0] high_water_ff, high_water_in;
   logic [IDX_W-1:0] cnt_ff;

   // Memories and their registered read data
   logic [HANDLE_BITS-1:0] handle_mem_ff [SLOTS];
   logic                   live_mem_ff   [SLOTS];
   logic [IDX_W-1:0]       stack_mem_ff  [SLOTS];
   logic [HANDLE_BITS-1:0] handle_q_ff;
   logic                   live_q_ff;
   logic [IDX_W-1:0]       stack_q_ff;

   // Result register
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [IDX_PORT_W-1:0]  rindex_ff, rindex_in;
   logic [HANDLE_BITS-1:0] rhandle_ff, rhandle_in;
   logic [CNT_PORT_W-1:0]  free_out_ff, used_out_ff;
   logic                   all_free_ff;

   // Write port controls
   logic                   live_we, live_wd, stack_we, handle_we;
   logic [IDX_W-1:0]       live_wa, stack_wa, stack_wd, handle_wa;

   logic [IDX_W-1:0]       slot_addr, live_ra, stack_ra;
   logic                   idx_valid, free_nz, hw_room;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         kind_ff   <= req_kind;
         idx_ff    <= req_slot_index;
         handle_ff <= req_handle;
      end
   end

   // Address and condition decode
   assign slot_addr = IDX_W'(idx_ff);
   assign live_ra   = cmd.clr_rd ? cnt_ff : slot_addr;
   assign stack_ra  = IDX_W'(free_top_ff - CNT_W'(1));
   assign free_nz   = (free_top_ff != '0);
   assign hw_room   = (high_water_ff != CNT_W'(SLOTS));
   // slots at or above the high-water mark were never written: gate them out
   assign idx_valid = (CMP_W'(idx_ff) < CMP_W'(high_water_ff)) && live_q_ff;

   // Operation commit and clear walk updates
   always_comb begin
      status_in     = STAT_OK;
      rindex_in     = '0;
      rhandle_in    = '0;
      live_we       = 1'b0;
      live_wa       = slot_addr;
      live_wd       = 1'b0;
      stack_we      = 1'b0;
      stack_wa      = IDX_W'(free_top_ff);
      stack_wd      = slot_addr;
      handle_we     = 1'b0;
      handle_wa     = stack_q_ff;
      free_top_in   = free_top_ff;
      high_water_in = high_water_ff;
      if (cmd.exec) begin
         unique case (kind_ff)
            KIND_ADD: begin
               if (handle_ff == '0) begin
                  status_in = STAT_NULL;
               end else if (free_nz) begin
                  // reuse the most recently freed slot
                  handle_we   = 1'b1;
                  handle_wa   = stack_q_ff;
                  live_we     = 1'b1;
                  live_wa     = stack_q_ff;
                  live_wd     = 1'b1;
                  free_top_in = free_top_ff - CNT_W'(1);
                  rindex_in   = IDX_PORT_W'(stack_q_ff);
               end else if (hw_room) begin
                  // take a fresh slot
                  handle_we     = 1'b1;
                  handle_wa     = IDX_W'(high_water_ff);
                  live_we       = 1'b1;
                  live_wa       = IDX_W'(high_water_ff);
                  live_wd       = 1'b1;
                  high_water_in = high_water_ff + CNT_W'(1);
                  rindex_in     = IDX_PORT_W'(high_water_ff);
               end else begin
                  status_in = STAT_FULL;
               end
            end
            KIND_REMOVE: begin
               rindex_in = idx_ff;
               if (idx_valid) begin
                  live_we     = 1'b1;
                  stack_we    = 1'b1;
                  free_top_in = free_top_ff + CNT_W'(1);
               end else begin
                  status_in = STAT_ABSENT;
               end
            end
            KIND_GET: begin
               rindex_in = idx_ff;
               if (idx_valid) begin
                  rhandle_in = handle_q_ff;
               end else begin
                  status_in = STAT_ABSENT;
               end
            end
            KIND_CLEAR: begin
               // walk already done; result carries counts only
            end
         endcase
      end else if (cmd.clr_wr && live_q_ff) begin
         // free a live slot found by the clear walk
         live_we     = 1'b1;
         live_wa     = cnt_ff;
         stack_we    = 1'b1;
         stack_wd    = cnt_ff;
         free_top_in = free_top_ff + CNT_W'(1);
      end
   end

   // Counters
   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff   <= '0;
         high_water_ff <= '0;
         cnt_ff        <= '0;
      end else begin
         free_top_ff   <= free_top_in;
         high_water_ff <= high_water_in;
         if (cmd.rd_req) begin
            cnt_ff <= '0;
         end else if (cmd.clr_wr) begin
            cnt_ff <= cnt_ff + IDX_W'(1);
         end
      end
   end

   // Handle memory
   always_ff @(posedge clock) begin
      if (handle_we) begin
         handle_mem_ff[handle_wa] <= handle_ff;
      end
      if (cmd.rd_req) begin
         handle_q_ff <= handle_mem_ff[slot_addr];
      end
   end

   // Live bit memory, valid below the high-water mark only
   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem_ff[live_wa] <= live_wd;
      end
      if (cmd.rd_req || cmd.clr_rd) begin
         live_q_ff <= live_mem_ff[live_ra];
      end
   end

   // Free index stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem_ff[stack_wa] <= stack_wd;
      end
      if (cmd.rd_req) begin
         stack_q_ff <= stack_mem_ff[stack_ra];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff   <= status_in;
         rindex_ff   <= rindex_in;
         rhandle_ff  <= rhandle_in;
         free_out_ff <= CNT_PORT_W'(free_top_in);
         used_out_ff <= CNT_PORT_W'(high_water_in);
         all_free_ff <= (free_top_in == high_water_in);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_result_index  = rindex_ff;
   assign rsp_result_handle = rhandle_ff;
   assign rsp_free_slots    = free_out_ff;
   assign rsp_slots_used    = used_out_ff;
   assign rsp_all_free      = all_free_ff;

   // Status to controller
   assign sts.is_clear = (kind_ff == KIND_CLEAR);
   assign sts.hw_zero  = (high_water_ff == '0);
   assign sts.clr_last = ((CNT_W'(cnt_ff) + CNT_W'(1)) == high_water_ff);

`ifndef SYNTHESIS
   // free stack never holds more slots than were created
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      free_top_ff <= high_water_ff)
      else $error("free stack deeper than high-water count");

   // high-water count only grows between resets
   a_hw_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> high_water_ff >= $past(high_water_ff))
      else $error("high-water count decreased");

   // a clear walk step never runs past the created slots
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> CNT_W'(cnt_ff) < high_water_ff)
      else $error("clear walk beyond high-water mark");
`endif

endmodule

>>> design/smfl_ctrl.sv
// ----------------------------------------------------------------------------
// smfl_ctrl
// Slot map controller: sequences request capture, memory read, clear walk
// and commit, and owns the request ready and result valid handshakes.
// ----------------------------------------------------------------------------
module smfl_ctrl
   import smfl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_CLR_RD = 3'd2;
   localparam logic [2:0] ST_CLR_WR = 3'd3;
   localparam logic [2:0] ST_EXEC   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       can_finish;

   // result register is free, or emptied by a transfer this cycle
   assign can_finish = !out_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_req = 1'b1;
            if (sts.is_clear && !sts.hw_zero) begin
               state_in = ST_CLR_RD;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_CLR_RD: begin
            cmd.clr_rd = 1'b1;
            state_in   = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            cmd.clr_wr = 1'b1;
            state_in   = sts.clr_last ? ST_EXEC : ST_CLR_RD;
         end
         ST_EXEC: begin
            if (can_finish) begin
               cmd.exec     = 1'b1;
               out_valid_in = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.ld_req = 1'b1;
                  state_in   = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

`ifndef SYNTHESIS
   // an accepted request always goes to the memory read step
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_READ)
      else $error("accepted request did not start a read");

   // commit only when the result register can take the new result
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("commit without result valid");

   // a clear walk read is always followed by its write step
   a_walk_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_rd |=> cmd.clr_wr)
      else $error("clear walk read not followed by write");
`endif

endmodule

>>> design/slot_map_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_map_free_list_allocator_top
// Slot table of object handles with a LIFO stack of freed slot indices.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one operation per transfer: add (store a nonzero handle),
//   remove (free a slot), get (read a live slot's handle) or clear (free all).
//   rsp_if returns exactly one result per request: status, slot index,
//   handle, free stack depth, high-water count and an all-free flag, all
//   taken after the operation.
//   Add, remove and get first read the handle, live bit and free stack
//   memories, then commit the write-back and load the result register. The
//   next request can be taken while the last one commits. Clear walks the
//   created slots through the live bit memory, reading each slot's live bit
//   and then freeing the slot if it is live, before its commit.
//   The result register holds while rsp_if.ready is low and a new request is
//   still taken; the next commit waits until the held result is transferred.
//   Reset empties the table at once (counts to zero); no clearing pass is
//   needed since slots above the high-water count are never read.
// ----------------------------------------------------------------------------
module slot_map_free_list_allocator_top
   import smfl_pkg::*;
#(
   parameter int SLOTS       = 64,
   parameter int HANDLE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   smfl_req_if.sink   req_if,
   smfl_rsp_if.source rsp_if
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencer
   smfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Memories, counters and result register
   smfl_dp #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_if.kind),
      .req_slot_index    (req_if.slot_index),
      .req_handle        (req_if.handle),
      .rsp_status        (rsp_if.status),
      .rsp_result_index  (rsp_if.result_index),
      .rsp_result_handle (rsp_if.result_handle),
      .rsp_free_slots    (rsp_if.free_slots),
      .rsp_slots_used    (rsp_if.slots_used),
      .rsp_all_free      (rsp_if.all_free)
   );

endmodule

>>> tb/sv/smfl_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfl_tb_pkg
// Request/result bundles and the scoreboard for the slot map testbench. The
// scoreboard keeps its own slot table, live bits and free-index stack, works
// out the result of every accepted request and checks the results in order.
// ----------------------------------------------------------------------------
package smfl_tb_pkg;
   import smfl_pkg::*;

   localparam int TB_SLOTS       = 64;
   localparam int TB_HANDLE_BITS = 32;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [IDX_PORT_W-1:0]     slot_index;
      logic [TB_HANDLE_BITS-1:0] handle;
   } slot_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic [IDX_PORT_W-1:0]     result_index;
      logic [TB_HANDLE_BITS-1:0] result_handle;
      logic [CNT_PORT_W-1:0]     free_slots;
      logic [CNT_PORT_W-1:0]     slots_used;
      logic                      all_free;
   } slot_rsp_type;

   class slot_map_checker;
      logic [TB_HANDLE_BITS-1:0] stored_handle [TB_SLOTS];
      bit                        slot_live     [TB_SLOTS];
      logic [IDX_PORT_W-1:0]     freed_stack   [TB_SLOTS];
      int                        free_depth;
      int                        high_water;
      slot_rsp_type              awaited_results [$];
      int                        errors;
      int                        n_kind   [4];
      int                        n_status [4];

      function new();
         free_depth = 0;
         high_water = 0;
         errors     = 0;
         foreach (slot_live[i]) begin
            slot_live[i]     = 1'b0;
            stored_handle[i] = '0;
            freed_stack[i]   = '0;
         end
         foreach (n_kind[i]) begin
            n_kind[i]   = 0;
            n_status[i] = 0;
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function int created();
         return high_water;
      endfunction

      // Random live slot, -1 when there is none
      function int pick_live();
         int cand [$];
         for (int i = 0; i < high_water; i++)
            if (slot_live[i]) cand.insert(cand.size(), i);
         if (cand.size() == 0) return -1;
         return cand[$urandom_range(cand.size() - 1, 0)];
      endfunction

      function void push_freed(int idx);
         if (free_depth < TB_SLOTS) begin
            freed_stack[free_depth] = IDX_PORT_W'(idx);
            free_depth++;
         end
      endfunction

      // Apply one accepted request to the table and queue its result
      function void predict_request(slot_req_type r);
         slot_rsp_type e;
         int           s;
         bit           addressed_live;
         e = '0;
         addressed_live = (int'(r.slot_index) < high_water) && slot_live[r.slot_index];
         case (r.kind)
            KIND_ADD: begin
               if (r.handle == '0) begin
                  e.status = STAT_NULL;
               end else if (free_depth > 0) begin
                  // reuse the most recently freed slot
                  free_depth--;
                  s = int'(freed_stack[free_depth]);
                  stored_handle[s] = r.handle;
                  slot_live[s]     = 1'b1;
                  e.result_index   = IDX_PORT_W'(s);
               end else if (high_water < TB_SLOTS) begin
                  s = high_water;
                  stored_handle[s] = r.handle;
                  slot_live[s]     = 1'b1;
                  high_water++;
                  e.result_index   = IDX_PORT_W'(s);
               end else begin
                  e.status = STAT_FULL;
               end
            end
            KIND_REMOVE: begin
               e.result_index = r.slot_index;
               if (addressed_live) begin
                  slot_live[r.slot_index] = 1'b0;
                  push_freed(int'(r.slot_index));
               end else begin
                  e.status = STAT_ABSENT;
               end
            end
            KIND_GET: begin
               e.result_index = r.slot_index;
               if (addressed_live) e.result_handle = stored_handle[r.slot_index];
               else e.status = STAT_ABSENT;
            end
            KIND_CLEAR: begin
               // ascending walk: highest live index ends on top
               for (int i = 0; i < high_water; i++) begin
                  if (slot_live[i]) begin
                     slot_live[i] = 1'b0;
                     push_freed(i);
                  end
               end
            end
         endcase
         e.free_slots = CNT_PORT_W'(free_depth);
         e.slots_used = CNT_PORT_W'(high_water);
         e.all_free   = (free_depth == high_water);
         n_kind[r.kind]++;
         n_status[e.status]++;
         awaited_results.insert(awaited_results.size(), e);
      endfunction

      function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compare one transferred result with the oldest expectation
      function void check_result(slot_rsp_type got);
         slot_rsp_type e;
         if (awaited_results.size() == 0) begin
            $error("unexpected result: index %0d, status %0d", got.result_index, got.status);
            errors++;
            return;
         end
         e = awaited_results.pop_front();
         compare_field("status",        e.status,        got.status);
         compare_field("result_index",  e.result_index,  got.result_index);
         compare_field("result_handle", e.result_handle, got.result_handle);
         compare_field("free_slots",    e.free_slots,    got.free_slots);
         compare_field("slots_used",    e.slots_used,    got.slots_used);
         compare_field("all_free",      e.all_free,      got.all_free);
      endfunction
   endclass

endpackage

>>> tb/sv/tb_slot_map_free_list_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_map_free_list_allocator_top
// Drives add, remove, get and clear requests into the slot map: a directed
// opening over the corner cases, then random traffic in episodes that fill,
// drain, mix or scramble the table, with random gaps and stalls on both
// channels. Every result is checked in order against the scoreboard.
// ----------------------------------------------------------------------------
module tb_slot_map_free_list_allocator_top;
   import smfl_pkg::*;
   import smfl_tb_pkg::*;

   localparam int TOTAL_REQS  = 1950;
   localparam int CYCLE_LIMIT = 800000;
   localparam int SETTLE      = 20;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} traffic_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   int   cycles = 0;
   int   sent   = 0;

   slot_map_checker sb = new();

   smfl_req_if #(.HANDLE_BITS(TB_HANDLE_BITS)) req_if ();
   smfl_rsp_if #(.HANDLE_BITS(TB_HANDLE_BITS)) rsp_if ();

   slot_map_free_list_allocator_top #(
      .SLOTS       (TB_SLOTS),
      .HANDLE_BITS (TB_HANDLE_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 27);
   end

   // Result monitor
   always @(posedge clock) begin
      slot_rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status        = rsp_if.status;
         got.result_index  = rsp_if.result_index;
         got.result_handle = rsp_if.result_handle;
         got.free_slots    = rsp_if.free_slots;
         got.slots_used    = rsp_if.slots_used;
         got.all_free      = rsp_if.all_free;
         sb.check_result(got);
      end
   end

   // One request transfer, with random idle cycles ahead of it
   task automatic send_req(input logic [KIND_W-1:0] kind, input int idx,
                           input logic [TB_HANDLE_BITS-1:0] handle);
      slot_req_type r;
      while (!steady && $urandom_range(99) < 27) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      r.kind       = kind;
      r.slot_index = IDX_PORT_W'(idx);
      r.handle     = handle;
      req_if.valid      <= 1'b1;
      req_if.kind       <= r.kind;
      req_if.slot_index <= r.slot_index;
      req_if.handle     <= r.handle;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.predict_request(r);
      sent++;
      @(negedge clock);
   endtask

   // Hold off until every outstanding result has been transferred
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic logic [TB_HANDLE_BITS-1:0] random_handle();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 8) return '1;
      if (r < 14) return TB_HANDLE_BITS'($urandom_range(255, 1));
      return $urandom();
   endfunction

   // Mostly created slots, live ones when asked, sometimes anywhere
   function automatic int random_slot(bit prefer_live);
      int r;
      int l;
      int hw;
      r  = $urandom_range(99);
      hw = sb.created();
      if (prefer_live) begin
         l = sb.pick_live();
         if (l >= 0 && r < 85) return l;
      end
      if (hw > 0 && r < 80) return $urandom_range(hw - 1, 0);
      return $urandom_range(TB_SLOTS - 1, 0);
   endfunction

   function automatic slot_req_type random_request(traffic_mix_type mix);
      slot_req_type q;
      int           r;
      int           add_pct;
      int           rem_pct;
      r = $urandom_range(999);
      q.slot_index = IDX_PORT_W'($urandom_range(TB_SLOTS - 1, 0));
      q.handle     = $urandom();
      if (mix == MIX_NOISE) begin
         q.kind = KIND_W'($urandom_range(3, 0));
         if (q.kind == KIND_ADD) q.handle = random_handle();
         return q;
      end
      if (r < 15) begin
         q.kind = KIND_CLEAR;
         return q;
      end
      case (mix)
         MIX_FILL:  begin add_pct = 85; rem_pct = 7;  end
         MIX_DRAIN: begin add_pct = 20; rem_pct = 60; end
         default:   begin add_pct = 40; rem_pct = 30; end
      endcase
      r = $urandom_range(99);
      if (r < add_pct) begin
         q.kind   = KIND_ADD;
         q.handle = random_handle();
      end else if (r < add_pct + rem_pct) begin
         q.kind       = KIND_REMOVE;
         q.slot_index = IDX_PORT_W'(random_slot(1'b1));
      end else begin
         q.kind       = KIND_GET;
         q.slot_index = IDX_PORT_W'(random_slot(1'($urandom_range(1))));
      end
      return q;
   endfunction

   initial begin
      slot_req_type    q;
      traffic_mix_type mix;
      int              episode_len;
      int              r;
      bit              first;

      req_if.valid      = 1'b0;
      req_if.kind       = KIND_ADD;
      req_if.slot_index = '0;
      req_if.handle     = '0;
      rsp_if.ready      = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: empty table, extremes, reuse, double free, clear
      send_req(KIND_GET,    0,  32'h0000_0001);  // nothing created yet
      send_req(KIND_REMOVE, 63, 32'hFFFF_FFFF);
      send_req(KIND_CLEAR,  0,  32'h0);          // clear on an empty table
      send_req(KIND_ADD,    63, 32'h0);          // null handle refused
      send_req(KIND_ADD,    0,  32'hFFFF_FFFF);  // slot 0
      send_req(KIND_ADD,    0,  32'h0000_0001);  // slot 1
      send_req(KIND_ADD,    0,  32'h8000_0000);  // slot 2
      send_req(KIND_GET,    0,  32'h0);
      send_req(KIND_GET,    2,  32'h0);
      send_req(KIND_GET,    3,  32'h0);          // beyond high water
      send_req(KIND_REMOVE, 0,  32'h0);
      send_req(KIND_REMOVE, 0,  32'h0);          // already free: refused
      send_req(KIND_GET,    0,  32'h0);          // freed slot not readable
      send_req(KIND_ADD,    0,  32'h1234_5678);  // slot 0 reused and live
      send_req(KIND_GET,    0,  32'h0);
      send_req(KIND_REMOVE, 1,  32'h0);
      send_req(KIND_REMOVE, 2,  32'h0);
      send_req(KIND_ADD,    0,  32'h5A5A_A5A5);  // LIFO: slot 2
      send_req(KIND_CLEAR,  63, 32'hFFFF_FFFF);
      send_req(KIND_ADD,    0,  32'h0000_00FF);  // slot 2 on top
      send_req(KIND_ADD,    0,  32'h0000_FF00);  // then 0
      send_req(KIND_ADD,    0,  32'h00FF_0000);  // then 1
      send_req(KIND_ADD,    0,  32'hFF00_0000);  // fresh slot 3
      send_req(KIND_GET,    63, 32'h0);
      send_req(KIND_CLEAR,  0,  32'h0);

      // Random episodes; the first is a fill episode of 110 requests
      first = 1'b1;
      while (sent < TOTAL_REQS) begin
         episode_len = $urandom_range(120, 20);
         if (first) begin
            mix = MIX_FILL;
            episode_len = 110;
         end else begin
            r = $urandom_range(99);
            if (r < 30)      mix = MIX_FILL;
            else if (r < 55) mix = MIX_DRAIN;
            else if (r < 90) mix = MIX_BALANCED;
            else             mix = MIX_NOISE;
         end
         if (first || $urandom_range(9) == 0) drain_results();
         steady = (sent >= 800 && sent < 1100);
         repeat (episode_len) begin
            q = random_request(mix);
            send_req(q.kind, int'(q.slot_index), q.handle);
         end
         first = 1'b0;
      end

      req_if.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("%0d requests: %0d add, %0d remove, %0d get, %0d clear",
               sent, sb.n_kind[KIND_ADD], sb.n_kind[KIND_REMOVE],
               sb.n_kind[KIND_GET], sb.n_kind[KIND_CLEAR]);
      $display("outcomes: %0d ok, %0d null handle, %0d table full, %0d absent slot",
               sb.n_status[STAT_OK], sb.n_status[STAT_NULL],
               sb.n_status[STAT_FULL], sb.n_status[STAT_ABSENT]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
design/smfl_pkg.sv
design/smfl_if.sv
design/smfl_dp.sv
design/smfl_ctrl.sv
design/slot_map_free_list_allocator_top.sv
tb/sv/smfl_tb_pkg.sv
tb/sv/tb_slot_map_free_list_allocator_top.sv
